/* hw/rtl/tlbpw_pkg.sv */
// Package for the TLB with two-level page walk: beat structs, result codes,
// walk phase and command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlbpw_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] linear_address;
    logic [31:0] cr3_value;
    logic        prot_en;
    logic        paging_enable;
    logic [31:0] read_data;
  } tlb_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
  } tlb_out_t;

  localparam logic       KIND_XLATE = 1'b0;
  localparam logic       KIND_DATA  = 1'b1;

  localparam logic [1:0] RK_READ  = 2'd0;
  localparam logic [1:0] RK_PHYS  = 2'd1;
  localparam logic [1:0] RK_FAULT = 2'd2;

  localparam int          LFSR_W    = 16;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam int          MOD_STEPS = 3;
  localparam int          MOD_CNT_W = 2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DIR   = 3'b010,
    PH_TABLE = 3'b100
  } phase_t;

  typedef enum logic [5:0] {
    RS_PASS  = 6'b000001,
    RS_DIR   = 6'b000010,
    RS_TBL   = 6'b000100,
    RS_FAULT = 6'b001000,
    RS_HIT   = 6'b010000,
    RS_FILL  = 6'b100000
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     phase_we;
    phase_t   phase_val;
    logic     inval;
    logic     pend_we;
    logic     sel_we;
    res_sel_t sel_val;
    logic     lookup;
    logic     fill_seq;
    logic     fill_victim;
    logic     mod_start;
    logic     mod_step;
    logic     out_load;
  } tlb_cmd_t;

  typedef struct packed {
    logic   kind;
    logic   bypass;
    logic   cr3_diff;
    phase_t phase;
    logic   present;
    logic   hit;
    logic   room;
    logic   mod_done;
    logic   out_free;
  } tlb_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tlbpw_ctrl.sv */
// Controller FSM for the TLB: sequences decode, lookup, victim reduction
// and result emission. Depends on tlbpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlbpw_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tlbpw_pkg::tlb_sts_t sts,
  output tlbpw_pkg::tlb_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_MODRED = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.phase_val = tlbpw_pkg::PH_IDLE;
    cmd.sel_val   = tlbpw_pkg::RS_PASS;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind == tlbpw_pkg::KIND_XLATE) begin
          cmd.phase_we = 1'b1;
          if (sts.bypass) begin
            cmd.sel_we  = 1'b1;
            cmd.sel_val = tlbpw_pkg::RS_PASS;
            state_nxt   = S_EMIT;
          end else if (sts.cr3_diff) begin
            // flush makes this a sure miss
            cmd.inval     = 1'b1;
            cmd.pend_we   = 1'b1;
            cmd.phase_val = tlbpw_pkg::PH_DIR;
            cmd.sel_we    = 1'b1;
            cmd.sel_val   = tlbpw_pkg::RS_DIR;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_LOOKUP;
          end
        end else begin
          case (sts.phase)
            tlbpw_pkg::PH_DIR: begin
              cmd.phase_we = 1'b1;
              cmd.sel_we   = 1'b1;
              if (!sts.present) begin
                cmd.phase_val = tlbpw_pkg::PH_IDLE;
                cmd.sel_val   = tlbpw_pkg::RS_FAULT;
              end else begin
                cmd.phase_val = tlbpw_pkg::PH_TABLE;
                cmd.sel_val   = tlbpw_pkg::RS_TBL;
              end
              state_nxt = S_EMIT;
            end
            tlbpw_pkg::PH_TABLE: begin
              cmd.phase_we  = 1'b1;
              cmd.phase_val = tlbpw_pkg::PH_IDLE;
              if (!sts.present) begin
                cmd.sel_we  = 1'b1;
                cmd.sel_val = tlbpw_pkg::RS_FAULT;
                state_nxt   = S_EMIT;
              end else if (sts.room) begin
                cmd.fill_seq = 1'b1;
                cmd.sel_we   = 1'b1;
                cmd.sel_val  = tlbpw_pkg::RS_FILL;
                state_nxt    = S_EMIT;
              end else begin
                cmd.mod_start = 1'b1;
                state_nxt     = S_MODRED;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        cmd.sel_we = 1'b1;
        if (sts.hit) begin
          cmd.sel_val = tlbpw_pkg::RS_HIT;
        end else begin
          cmd.pend_we   = 1'b1;
          cmd.phase_we  = 1'b1;
          cmd.phase_val = tlbpw_pkg::PH_DIR;
          cmd.sel_val   = tlbpw_pkg::RS_DIR;
        end
        state_nxt = S_EMIT;
      end
      S_MODRED: begin
        if (sts.mod_done) begin
          cmd.fill_victim = 1'b1;
          cmd.sel_we      = 1'b1;
          cmd.sel_val     = tlbpw_pkg::RS_FILL;
          state_nxt       = S_EMIT;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded next cycle");

  a_modred_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MODRED) |-> !sts.room)
    else $error("victim pick while free slots remain");

  a_lookup_after_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP) |-> ($past(state_r) == S_DECODE))
    else $error("lookup without decode");

endmodule

`default_nettype wire

/* hw/rtl/tlbpw_dp.sv */
// Datapath for the TLB: entry tags and valids, frame base memory, walk
// registers, fill counter, victim LFSR with mod reducer, output register.
// Depends on tlbpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlbpw_dp #(
  parameter int TLB_ENTRIES = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tlbpw_pkg::tlb_in_t  in_data,
  input  wire tlbpw_pkg::tlb_cmd_t cmd,
  output tlbpw_pkg::tlb_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlbpw_pkg::tlb_out_t      out_data
);

  localparam int IDX_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W    = $clog2(TLB_ENTRIES + 1);
  localparam int RECIP_SH = 26;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = tlbpw_pkg::LFSR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / 64'(TLB_ENTRIES));
  localparam logic [tlbpw_pkg::LFSR_W-1:0] N_VAL = tlbpw_pkg::LFSR_W'(TLB_ENTRIES);

  tlbpw_pkg::tlb_in_t             in_r;
  logic [31:0]                    saved_cr3_r;
  tlbpw_pkg::phase_t              phase_r;
  logic [31:0]                    pend_r;
  logic [CNT_W-1:0]               fill_cnt_r;
  logic [tlbpw_pkg::LFSR_W-1:0]   lfsr_r;
  logic [TLB_ENTRIES-1:0]         valid_r;
  logic [19:0]                    tag_r [TLB_ENTRIES];
  logic [19:0]                    base_mem [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]         match_r;
  logic [19:0]                    base_rd_r;
  logic [tlbpw_pkg::LFSR_W-1:0]   rem_r;
  logic [tlbpw_pkg::LFSR_W-1:0]   lfsr_cap_r;
  logic [tlbpw_pkg::LFSR_W-1:0]   qn_r;
  logic [PROD_W-1:0]              prod_r;
  logic [tlbpw_pkg::MOD_CNT_W-1:0] mod_cnt_r;
  tlbpw_pkg::res_sel_t            sel_r;
  logic                           out_valid_r;
  tlbpw_pkg::tlb_out_t            out_data_r;

  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               slot;
  logic                           fill_we;
  logic                           lfsr_fb;
  tlbpw_pkg::tlb_out_t            out_nxt;

  assign fill_we = cmd.fill_seq | cmd.fill_victim;
  assign slot    = cmd.fill_victim ? rem_r[IDX_W-1:0] : fill_cnt_r[IDX_W-1:0];
  assign lfsr_fb = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_cr3_r <= '0;
      phase_r     <= tlbpw_pkg::PH_IDLE;
      pend_r      <= '0;
      fill_cnt_r  <= '0;
      lfsr_r      <= tlbpw_pkg::LFSR_SEED;
      valid_r     <= '0;
      match_r     <= '0;
      mod_cnt_r   <= '0;
    end else begin
      if (cmd.phase_we) begin
        phase_r <= cmd.phase_val;
      end
      if (cmd.pend_we) begin
        pend_r <= in_r.linear_address;
      end
      if (cmd.inval) begin
        saved_cr3_r <= in_r.cr3_value;
        fill_cnt_r  <= '0;
        valid_r     <= '0;
      end else begin
        if (cmd.fill_seq) begin
          fill_cnt_r <= fill_cnt_r + CNT_W'(1);
        end
        if (fill_we) begin
          valid_r[slot] <= 1'b1;
        end
      end
      if (cmd.fill_victim) begin
        lfsr_r <= {lfsr_fb, lfsr_r[tlbpw_pkg::LFSR_W-1:1]};
      end
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && (tag_r[i] == in_r.linear_address[31:12]);
      end
      if (cmd.mod_start) begin
        mod_cnt_r <= '0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + tlbpw_pkg::MOD_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      tag_r[slot]    <= pend_r[31:12];
      base_mem[slot] <= in_r.read_data[31:12];
    end
    if (cmd.lookup) begin
      base_rd_r <= base_mem[hit_idx];
    end
  end

  // tags are unique among valid entries, so an OR encode is exact
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // victim slot: lfsr mod TLB_ENTRIES by reciprocal multiply; the quotient
  // estimate is low by at most one, so one compare and subtract finishes it
  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      lfsr_cap_r <= lfsr_r;
      prod_r     <= PROD_W'(lfsr_r) * PROD_W'(RECIP);
    end else if (cmd.mod_step) begin
      if (mod_cnt_r == tlbpw_pkg::MOD_CNT_W'(0)) begin
        qn_r <= prod_r[RECIP_SH +: tlbpw_pkg::LFSR_W] * N_VAL;
      end else if (mod_cnt_r == tlbpw_pkg::MOD_CNT_W'(1)) begin
        rem_r <= lfsr_cap_r - qn_r;
      end else if (rem_r >= N_VAL) begin
        rem_r <= rem_r - N_VAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_we) begin
      sel_r <= cmd.sel_val;
    end
  end

  always_comb begin
    case (sel_r)
      tlbpw_pkg::RS_PASS: begin
        out_nxt = '{tlbpw_pkg::RK_PHYS, in_r.linear_address};
      end
      tlbpw_pkg::RS_DIR: begin
        out_nxt = '{tlbpw_pkg::RK_READ,
                    {in_r.cr3_value[31:12], in_r.linear_address[31:22], 2'b00}};
      end
      tlbpw_pkg::RS_TBL: begin
        out_nxt = '{tlbpw_pkg::RK_READ,
                    {in_r.read_data[31:12], pend_r[21:12], 2'b00}};
      end
      tlbpw_pkg::RS_FAULT: begin
        out_nxt = '{tlbpw_pkg::RK_FAULT, pend_r};
      end
      tlbpw_pkg::RS_HIT: begin
        out_nxt = '{tlbpw_pkg::RK_PHYS, {base_rd_r, in_r.linear_address[11:0]}};
      end
      tlbpw_pkg::RS_FILL: begin
        out_nxt = '{tlbpw_pkg::RK_PHYS, {in_r.read_data[31:12], pend_r[11:0]}};
      end
      default: begin
        out_nxt = '{tlbpw_pkg::RK_PHYS, in_r.linear_address};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.kind     = in_r.kind;
  assign sts.bypass   = !(in_r.prot_en && in_r.paging_enable);
  assign sts.cr3_diff = (in_r.cr3_value != saved_cr3_r);
  assign sts.phase    = phase_r;
  assign sts.present  = in_r.read_data[0];
  assign sts.hit      = |match_r;
  assign sts.room     = (fill_cnt_r < CNT_W'(TLB_ENTRIES));
  assign sts.mod_done = (mod_cnt_r == tlbpw_pkg::MOD_CNT_W'(tlbpw_pkg::MOD_STEPS));
  assign sts.out_free = !out_valid_r || out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(TLB_ENTRIES))
    else $error("fill count past table size");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_r))
    else $error("duplicate valid tag in TLB");

  a_lfsr_live: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("victim LFSR locked at zero");

endmodule

`default_nettype wire

/* hw/rtl/tlb_with_two_level_page_walk.sv */
// Top level of the TLB with two-level page walk: controller plus datapath.
// Depends on tlbpw_pkg, tlbpw_ctrl, tlbpw_dp.
//
//   channel  ports                          beat
//   in       in_valid/in_ready/in_data      translate request or walk read data
//   out      out_valid/out_ready/out_data   read request, physical addr, fault
//
// One beat at a time. Bypass, flush-miss and walk steps go through accept,
// decode and emit; a TLB lookup goes through accept, decode with match
// register, base memory read and emit; a fill into a full table adds the LFSR
// mod-TLB_ENTRIES reduction. Walk data while idle is dropped. Emit waits while
// the output register holds an unaccepted beat; input is taken again once set.
// Reset clears valids, fill count, saved CR3, walk phase; LFSR seeds to ACE1.
`timescale 1ns / 1ps
`default_nettype none

module tlb_with_two_level_page_walk #(
  parameter int TLB_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tlbpw_pkg::tlb_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tlbpw_pkg::tlb_out_t     out_data
);

  tlbpw_pkg::tlb_cmd_t cmd;
  tlbpw_pkg::tlb_sts_t sts;

  tlbpw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlbpw_dp #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
